FILE: src/disparity_to_point_reprojection_defines.svh
// Assertion macros for the reprojection block
`ifndef DISPARITY_TO_POINT_REPROJECTION_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECTION_DEFINES_SVH
// implication checked every clock outside reset
`define DPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpr check failed");
// next-cycle implication
`define DPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpr check failed");
`endif

FILE: src/dpr_pkg.sv
// Shared types and constants of the reprojection block
package dpr_pkg;
  localparam int unsigned NUM_W  = 50;
  localparam int unsigned DEN_W  = 48;
  localparam int unsigned Q_W    = 34;
  localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;

  typedef enum logic [2:0] {
    REG_X_START = 3'd0, REG_Y_START = 3'd1, REG_WIDTH = 3'd2, REG_HEIGHT = 3'd3,
    REG_FOCAL = 3'd4, REG_INV_BASE = 3'd5, REG_COLOR = 3'd6, REG_NONE = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    CM_NONE = 2'd0, CM_GRAY = 2'd1, CM_RGB = 2'd2, CM_UNUSED = 2'd3
  } color_mode_t;

  // job handed from the front part to the back part
  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [NUM_W-1:0] num_z;
    logic        [7:0]       red;
    logic        [7:0]       green;
    logic        [7:0]       blue;
    logic        [20:0]      count;
  } job_t;
endpackage

FILE: src/dpr_front.sv
// Front part: pixel counters, divisor product, numerators and color selection
module dpr_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  disparity,
  input  logic [7:0]          chan_first,
  input  logic [7:0]          chan_second,
  input  logic [7:0]          chan_third,
  input  logic signed [31:0]  x_start,
  input  logic signed [31:0]  y_start,
  input  logic [10:0]         window_width,
  input  logic [10:0]         window_height,
  input  logic signed [31:0]  focal_length,
  input  logic signed [31:0]  inv_baseline_scaled,
  input  logic [1:0]          color_mode,
  output logic                job_valid,
  input  logic                job_stall,
  output dpr_pkg::job_t       job,
  output logic signed [dpr_pkg::DEN_W-1:0] job_den
);
  import dpr_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH) + 1;
  localparam int RW = $clog2(MAX_HEIGHT) + 1;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [20:0]   points_emitted;
  logic [12:0]   ew, eh;
  logic [CW-1:0] col_eff, col_inc;
  logic [RW-1:0] row_eff, row_inc;
  logic          take, emit;
  logic [20:0]   cnt_next;
  logic [7:0]    r, g, b;

  // clamp the window size into 1..MAX
  always_comb begin
    ew = (window_width == 11'd0) ? 13'd1 :
         ({2'b0, window_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b0, window_width};
    eh = (window_height == 11'd0) ? 13'd1 :
         ({2'b0, window_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {2'b0, window_height};
  end

  assign in_stall = job_valid && job_stall;
  assign take     = in_valid && !in_stall;
  assign emit     = disparity > 16'sd0;

  always_comb begin
    col_eff  = (13'(col) >= ew) ? '0 : col;
    row_eff  = (13'(row) >= eh) ? '0 : row;
    col_inc  = col_eff + 1'b1;
    row_inc  = row_eff + 1'b1;
    cnt_next = (emit && points_emitted != COUNT_MAX) ? points_emitted + 1'b1 : points_emitted;
    case (color_mode_t'(color_mode))
      CM_GRAY: begin r = chan_first; g = chan_first; b = chan_first; end
      CM_RGB:  begin r = chan_first; g = chan_second; b = chan_third; end
      default: begin r = '0; g = '0; b = '0; end
    endcase
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; points_emitted <= '0;
    end else if (take) begin
      if (13'(col_inc) >= ew) begin
        col <= '0;
        if (13'(row_inc) >= eh) begin
          row <= '0; points_emitted <= '0;
        end else begin
          row <= row_inc; points_emitted <= cnt_next;
        end
      end else begin
        col <= col_inc; row <= row_eff; points_emitted <= cnt_next;
      end
    end
  end

  // registered job: one 32x16 product and three numerators
  always_ff @(posedge clk) begin
    if (rst) job_valid <= 1'b0;
    else if (!in_stall) job_valid <= take && emit;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_den     <= DEN_W'(inv_baseline_scaled) * DEN_W'(disparity);
      job.num_x   <= NUM_W'(x_start) + NUM_W'(signed'({1'b0, col_eff, 16'b0}));
      job.num_y   <= NUM_W'(y_start) + NUM_W'(signed'({1'b0, row_eff, 16'b0}));
      job.num_z   <= NUM_W'(focal_length);
      job.red     <= r;
      job.green   <= g;
      job.blue    <= b;
      job.count   <= cnt_next;
    end
  end
endmodule

FILE: src/dpr_fifo.sv
// Short queue between the front and back parts
module dpr_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_stall,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_stall,
  output logic [W-1:0] rd_data
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   fill;
  logic          wr, rd;

  assign wr_stall = (fill == (AW+1)'(DEPTH));
  assign rd_valid = (fill != '0);
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_valid && !rd_stall;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      fill <= fill + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

FILE: src/dpr_back.sv
// Back part: serial restoring divider for the three coordinates, one output register
module dpr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  output logic                             job_stall,
  input  dpr_pkg::job_t                    job,
  input  logic signed [dpr_pkg::DEN_W-1:0] job_den,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               point_x,
  output logic signed [31:0]               point_y,
  output logic signed [31:0]               point_z,
  output logic [7:0]                       color_red,
  output logic [7:0]                       color_green,
  output logic [7:0]                       color_blue,
  output logic [20:0]                      point_number
);
  import dpr_pkg::*;
  `include "disparity_to_point_reprojection_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_DIV = 3'b010, ST_OUT = 3'b100
  } state_t;

  localparam int SH_W = NUM_W + 16;   // magnitude of N * 2^16 plus rounding
  state_t        state;
  job_t          cur;
  logic [DEN_W-1:0] up;
  logic          pneg;
  logic [1:0]    sel;
  logic [6:0]    bitn;
  logic [SH_W:0] dvd;           // dividend shifted out msb first
  logic [DEN_W:0] rem;
  logic [Q_W+31:0] quo;
  logic          qneg;
  logic [31:0]   res [3];
  logic signed [NUM_W-1:0] n_sel;
  logic [NUM_W-1:0] n_mag;
  logic [DEN_W:0] rem_sh, rem_sub;
  logic [31:0]   sat;
  logic          over;

  assign job_stall = (state != ST_IDLE);

  always_comb begin
    case (sel)
      2'd0:    n_sel = cur.num_x;
      2'd1:    n_sel = cur.num_y;
      default: n_sel = cur.num_z;
    endcase
    n_mag   = n_sel[NUM_W-1] ? NUM_W'(-n_sel) : NUM_W'(n_sel);
    rem_sh  = {rem[DEN_W-1:0], dvd[SH_W]};
    rem_sub = rem_sh - {1'b0, up};
    // saturation of the finished quotient
    over = qneg ? (quo > 66'h80000000) : (quo > 66'h7FFFFFFF);
    if (up == '0)
      sat = (n_sel == '0) ? 32'h0 : n_sel[NUM_W-1] ? 32'h80000000 : 32'h7FFFFFFF;
    else if (over)
      sat = qneg ? 32'h80000000 : 32'h7FFFFFFF;
    else
      sat = qneg ? 32'(-quo[31:0]) : quo[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (job_valid) begin
          cur   <= job;
          up    <= job_den[DEN_W-1] ? DEN_W'(-job_den) : DEN_W'(job_den);
          pneg  <= job_den[DEN_W-1];
          sel   <= 2'd0;
          bitn  <= '0;
          rem   <= '0;
          quo   <= '0;
          dvd   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (bitn == 7'd0) begin
            // load numerator: (|N| << 16) + |P|/2, the half added for rounding
            dvd  <= (SH_W+1)'({n_mag, 16'b0}) + (SH_W+1)'(up >> 1);
            qneg <= n_sel[NUM_W-1] ^ pneg;
            rem  <= '0;
            quo  <= '0;
            bitn <= 7'd1;
          end else if (bitn == 7'(SH_W + 2)) begin
            // quotient complete: keep X or Y and start the next one, or go to output after Z
            bitn <= '0;
            if (sel != 2'd2) begin
              res[sel] <= sat;
              sel      <= sel + 1'b1;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            if (!rem_sub[DEN_W]) begin
              rem <= rem_sub; quo <= {quo[Q_W+30:0], 1'b1};
            end else begin
              rem <= rem_sh;  quo <= {quo[Q_W+30:0], 1'b0};
            end
            dvd  <= {dvd[SH_W-1:0], 1'b0};
            bitn <= bitn + 1'b1;
          end
        end
        ST_OUT: if (!out_valid || !out_stall) begin
          point_x      <= res[0];
          point_y      <= res[1];
          point_z      <= sat;
          color_red    <= cur.red;
          color_green  <= cur.green;
          color_blue   <= cur.blue;
          point_number <= cur.count;
          out_valid    <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == ST_OUT)) out_valid <= 1'b0;
    end
  end

  `DPR_ASSERT_IMP(a_stall_busy, state != ST_IDLE, job_stall)
  `DPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `DPR_ASSERT_IMP(a_sel_range, state == ST_DIV, sel != 2'd3)
endmodule

FILE: src/disparity_to_point_reprojection.sv
// Top level of the disparity to 3D point reprojection block
// Usage:
//  Input channel (in_valid/in_stall) takes one disparity pixel beat per pixel of
//  the window in raster order, with its color. The block keeps column and row
//  counters; a pixel with disparity of zero or less yields no output beat.
//  Output channel (out_valid/out_stall) gives X, Y, Z in Q16.16, the color and
//  the running point count of the window.
//  Configuration: cfg_write with cfg_index/cfg_data, only while idle.
//  From input beat to output beat a point passes the front job register, the
//  queue and the back part; the back part takes a new point only when done with
//  the last. The serial restoring divider (one quotient bit per cycle, shared by
//  the three coordinates) sets the pace. Pixels with no point make no job.
//  A four-beat queue parts the front and back parts.
//  Reset clears counters, queue and output valid and loads register defaults.
//  When the receiver stalls, the output beat holds and the queue fills, then
//  in_stall rises.
module disparity_to_point_reprojection #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] disparity,
  input  logic [7:0]         chan_first,
  input  logic [7:0]         chan_second,
  input  logic [7:0]         chan_third,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [7:0]         color_red,
  output logic [7:0]         color_green,
  output logic [7:0]         color_blue,
  output logic [20:0]        point_number
);
  import dpr_pkg::*;

  logic signed [31:0] x_start, y_start, focal_length, inv_baseline_scaled;
  logic [10:0] window_width, window_height;
  logic [1:0]  color_mode;
  logic        fj_valid, fj_stall, bj_valid, bj_stall;
  job_t        fj, bj;
  logic signed [DEN_W-1:0] fden, bden;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_start <= '0; y_start <= '0; window_width <= 11'd640; window_height <= 11'd480;
      focal_length <= '0; inv_baseline_scaled <= 32'sd65536; color_mode <= CM_NONE;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_X_START:  x_start <= cfg_data;
        REG_Y_START:  y_start <= cfg_data;
        REG_WIDTH:    window_width <= cfg_data[10:0];
        REG_HEIGHT:   window_height <= cfg_data[10:0];
        REG_FOCAL:    focal_length <= cfg_data;
        REG_INV_BASE: inv_baseline_scaled <= cfg_data;
        REG_COLOR:    color_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  dpr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .disparity, .chan_first, .chan_second,
    .chan_third, .x_start, .y_start, .window_width, .window_height,
    .focal_length, .inv_baseline_scaled, .color_mode,
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj), .job_den(fden)
  );

  dpr_fifo #(.W($bits(job_t) + DEN_W), .DEPTH(4)) u_fifo (
    .clk, .rst, .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data({fj, fden}),
    .rd_valid(bj_valid), .rd_stall(bj_stall), .rd_data({bj, bden})
  );

  dpr_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_stall(bj_stall), .job(bj), .job_den(bden),
    .out_valid, .out_stall, .point_x, .point_y, .point_z, .color_red,
    .color_green, .color_blue, .point_number
  );
endmodule
